[rtl/core/tcvd_pkg.sv]
// ----------------------------------------------------------------------------
// tcvd_pkg
// shared constants, control types and key helpers of the triad chord decoder
// ----------------------------------------------------------------------------
`default_nettype none

package tcvd_pkg;

  localparam int MaxBeats  = 64;
  localparam int NStates   = 24;
  localparam int NBins     = 12;
  localparam int BinW      = 16;
  localparam int ScoreW    = 24;
  localparam int BeatW     = $clog2(MaxBeats + 1);
  localparam int BeatIdxW  = 6;
  localparam int StateW    = $clog2(NStates);
  localparam int LinkAw    = $clog2(MaxBeats * NStates);
  localparam int SumW      = 20;   // sum of twelve bins
  localparam int SqW       = 36;   // sum of twelve squared bins
  localparam int N2W       = 40;
  localparam int DW        = 42;
  localparam int QuoBits   = 28;
  localparam int SqrtBits  = 14;
  localparam int StepW     = 5;
  localparam int CfgIdxW   = 2;
  localparam int CfgDataW  = 16;

  localparam logic [CfgIdxW-1:0] CfgKeyTonic    = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgKeyMajor    = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgStayBonus   = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgDiatonicBias = 2'd3;

  localparam logic [1:0] KindMajor = 2'd0;
  localparam logic [1:0] KindMinor = 2'd1;
  localparam logic [1:0] KindDim   = 2'd2;

  typedef struct packed {
    logic bin_take;
    logic prep_sq;
    logic prep_d;
    logic em_n;
    logic em_sq;
    logic em_chk;
    logic div_step;
    logic sqrt_step;
    logic em_fin;
    logic acs_step;
    logic wr;
    logic copy;
    logic pick_step;
    logic tb_init;
    logic tb_read;
    logic tb_load;
    logic tb_done;
  } cmd_t;

  typedef struct packed {
    logic bin_last;
    logic fin;
    logic beat_full;
    logic beat_zero;
    logic d_zero;
    logic n2_ge_d;
    logic div_last;
    logic sqrt_last;
    logic p_last;
    logic s_last;
    logic tb_zero;
  } sts_t;

  // diatonic quality of a root in the configured key
  function automatic logic [1:0] diatonic_kind(input logic [3:0] root,
                                               input logic [3:0] tonic,
                                               input logic       major);
    logic [5:0] deg;
    logic [1:0] kind;
    deg = 6'(root) + 6'd24 - 6'(tonic);
    if (deg >= 6'd24) deg = deg - 6'd24;
    if (deg >= 6'd12) deg = deg - 6'd12;
    if (major) begin
      if (deg == 6'd2 || deg == 6'd4 || deg == 6'd9) kind = KindMinor;
      else if (deg == 6'd11)                         kind = KindDim;
      else                                           kind = KindMajor;
    end else begin
      if (deg == 6'd2)                               kind = KindDim;
      else if (deg == 6'd3 || deg == 6'd7 || deg == 6'd8 || deg == 6'd10)
                                                     kind = KindMajor;
      else                                           kind = KindMinor;
    end
    return kind;
  endfunction

endpackage

`default_nettype wire

[rtl/core/triad_chord_viterbi_decoder_unit.sv]
// ----------------------------------------------------------------------------
// triad_chord_viterbi_decoder_unit
// chord decoder over the 24 major and minor triads from beat chroma
// ----------------------------------------------------------------------------
// chroma bins enter one item per cycle, pitch class c first, twelve per beat,
// while the block sits in collection. after the twelfth bin the input stalls
// while the beat is scored: for each of the 24 triads the correlation is
// found by a 28-step restoring divider and a 14-step square root unit, then
// an add-compare-select sweep over the stored path scores runs. the divider
// and root are skipped where the chroma is flat or a template matches fully;
// the first beat skips the sweeps. the beat flagged final then runs a
// best-state pick and a traceback that shows the result items last beat
// first, reading the back-link memory (one write port, one registered read
// port) between items. beats beyond 64 are dropped. configuration writes
// are taken at any time but belong only in idle periods.
// ----------------------------------------------------------------------------
`default_nettype none

module triad_chord_viterbi_decoder_unit (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // bin items in
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic [tcvd_pkg::BinW-1:0]       bin_value_i,
  input  wire logic                            final_beat_i,
  // chord items out
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic [3:0]                           chord_root_o,
  output logic                                 chord_minor_o,
  output logic [tcvd_pkg::BeatIdxW-1:0]        beat_index_o,
  output logic                                 last_chord_o,
  // register writes
  input  wire logic                            cfg_we_i,
  input  wire logic [tcvd_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire logic [tcvd_pkg::CfgDataW-1:0]   cfg_data_i
);

  tcvd_pkg::cmd_t cmd;
  tcvd_pkg::sts_t sts;

  // sequencer
  tcvd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // arithmetic, scores and link store
  tcvd_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .bin_value_i   (bin_value_i),
    .final_beat_i  (final_beat_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .chord_root_o  (chord_root_o),
    .chord_minor_o (chord_minor_o),
    .beat_index_o  (beat_index_o),
    .last_chord_o  (last_chord_o)
  );

endmodule

`default_nettype wire

[rtl/core/tcvd_ctrl.sv]
// ----------------------------------------------------------------------------
// tcvd_ctrl
// sequencer: bin collection, emission, add-compare-select, pick and traceback
// ----------------------------------------------------------------------------
`default_nettype none

module tcvd_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  input  tcvd_pkg::sts_t     sts_i,
  output tcvd_pkg::cmd_t     cmd_o
);

  typedef enum logic [16:0] {
    S_COLLECT = 17'h00001,
    S_PREP_SQ = 17'h00002,
    S_PREP_D  = 17'h00004,
    S_EM_N    = 17'h00008,
    S_EM_SQ   = 17'h00010,
    S_EM_CHK  = 17'h00020,
    S_DIV     = 17'h00040,
    S_SQRT    = 17'h00080,
    S_EM_FIN  = 17'h00100,
    S_ACS     = 17'h00200,
    S_WR      = 17'h00400,
    S_COPY    = 17'h00800,
    S_PICK    = 17'h01000,
    S_TB_INIT = 17'h02000,
    S_TB_OUT  = 17'h04000,
    S_TB_RD   = 17'h08000,
    S_TB_LD   = 17'h10000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_COLLECT;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o  = (state_q != S_COLLECT);
  assign out_valid_o = (state_q == S_TB_OUT);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_COLLECT: begin
        if (in_valid_i) begin
          cmd_o.bin_take = 1'b1;
          if (sts_i.bin_last) state_d = S_PREP_SQ;
        end
      end
      S_PREP_SQ: begin
        cmd_o.prep_sq = 1'b1;
        if (!sts_i.beat_full) state_d = S_PREP_D;
        else if (sts_i.fin)   state_d = S_PICK;
        else                  state_d = S_COLLECT;
      end
      S_PREP_D: begin
        cmd_o.prep_d = 1'b1;
        state_d      = S_EM_N;
      end
      S_EM_N: begin
        cmd_o.em_n = 1'b1;
        state_d    = S_EM_SQ;
      end
      S_EM_SQ: begin
        cmd_o.em_sq = 1'b1;
        state_d     = S_EM_CHK;
      end
      S_EM_CHK: begin
        cmd_o.em_chk = 1'b1;
        state_d      = (sts_i.d_zero || sts_i.n2_ge_d) ? S_EM_FIN : S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) state_d = S_SQRT;
      end
      S_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        if (sts_i.sqrt_last) state_d = S_EM_FIN;
      end
      S_EM_FIN: begin
        cmd_o.em_fin = 1'b1;
        state_d      = sts_i.beat_zero ? S_WR : S_ACS;
      end
      S_ACS: begin
        cmd_o.acs_step = 1'b1;
        if (sts_i.p_last) state_d = S_WR;
      end
      S_WR: begin
        cmd_o.wr = 1'b1;
        state_d  = sts_i.s_last ? S_COPY : S_EM_N;
      end
      S_COPY: begin
        cmd_o.copy = 1'b1;
        state_d    = sts_i.fin ? S_PICK : S_COLLECT;
      end
      S_PICK: begin
        cmd_o.pick_step = 1'b1;
        if (sts_i.p_last) state_d = S_TB_INIT;
      end
      S_TB_INIT: begin
        cmd_o.tb_init = 1'b1;
        state_d       = S_TB_OUT;
      end
      S_TB_OUT: begin
        if (!out_stall_i) begin
          if (sts_i.tb_zero) begin
            cmd_o.tb_done = 1'b1;
            state_d       = S_COLLECT;
          end else begin
            state_d = S_TB_RD;
          end
        end
      end
      S_TB_RD: begin
        cmd_o.tb_read = 1'b1;
        state_d       = S_TB_LD;
      end
      S_TB_LD: begin
        cmd_o.tb_load = 1'b1;
        state_d       = S_TB_OUT;
      end
      default: begin
        state_d = S_COLLECT;
      end
    endcase
  end

endmodule

`default_nettype wire

[rtl/core/tcvd_dpath.sv]
// ----------------------------------------------------------------------------
// tcvd_dpath
// bin store, correlation divider and root unit, score registers, link memory
// ----------------------------------------------------------------------------
`default_nettype none

module tcvd_dpath (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic [tcvd_pkg::BinW-1:0]       bin_value_i,
  input  wire logic                            final_beat_i,
  input  wire logic                            cfg_we_i,
  input  wire logic [tcvd_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire logic [tcvd_pkg::CfgDataW-1:0]   cfg_data_i,
  input  tcvd_pkg::cmd_t                       cmd_i,
  output tcvd_pkg::sts_t                       sts_o,
  output logic [3:0]                           chord_root_o,
  output logic                                 chord_minor_o,
  output logic [tcvd_pkg::BeatIdxW-1:0]        beat_index_o,
  output logic                                 last_chord_o
);

  localparam int SW = tcvd_pkg::ScoreW;

  // configuration
  logic [3:0]         tonic_q;
  logic               major_q;
  logic signed [15:0] stay_q;
  logic signed [15:0] dbias_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tonic_q <= '0;
      major_q <= 1'b1;
      stay_q  <= '0;
      dbias_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tcvd_pkg::CfgKeyTonic:     tonic_q <= cfg_data_i[3:0];
        tcvd_pkg::CfgKeyMajor:     major_q <= cfg_data_i[0];
        tcvd_pkg::CfgStayBonus:    stay_q  <= cfg_data_i;
        tcvd_pkg::CfgDiatonicBias: dbias_q <= cfg_data_i;
        default:                   tonic_q <= tonic_q;
      endcase
    end
  end

  // counters
  logic [3:0]                       bin_cnt_q;
  logic [tcvd_pkg::BeatW-1:0]       beat_q;
  logic [tcvd_pkg::StateW-1:0]      s_q, p_q;
  logic [tcvd_pkg::StepW-1:0]       step_q;

  // payload
  logic [tcvd_pkg::BinW-1:0]        bins_q [tcvd_pkg::NBins];
  logic                             fin_q;
  logic [tcvd_pkg::SumW-1:0]        a_q;
  logic [tcvd_pkg::SqW-1:0]         q_q;
  logic [tcvd_pkg::N2W-1:0]         asq_q;
  logic [tcvd_pkg::DW-1:0]          d_q;
  logic                             nneg_q;
  logic [tcvd_pkg::SumW-1:0]        nmag_q;
  logic [tcvd_pkg::N2W-1:0]         n2_q;
  logic [tcvd_pkg::DW:0]            rem_q;
  logic [tcvd_pkg::QuoBits-1:0]     quo_q;
  logic [tcvd_pkg::QuoBits-1:0]     sq_op_q, sq_res_q, sq_one_q;
  logic [14:0]                      k_q;
  logic signed [15:0]               em_q;
  logic signed [SW:0]               best_q;
  logic [tcvd_pkg::StateW-1:0]      arg_q;
  logic signed [SW-1:0]             ps_q [tcvd_pkg::NStates];
  logic signed [SW-1:0]             nx_q [tcvd_pkg::NStates];
  logic [tcvd_pkg::BeatIdxW-1:0]    tb_b_q;
  logic [tcvd_pkg::StateW-1:0]      tb_s_q;
  logic [tcvd_pkg::StateW-1:0]      rd_q;
  logic [tcvd_pkg::StateW-1:0]      link_mem [tcvd_pkg::MaxBeats * tcvd_pkg::NStates];

  // combinational helpers
  logic [31:0]                      xsq;
  logic [17:0]                      tsum;
  logic signed [21:0]               nval;
  logic [tcvd_pkg::DW:0]            r2;
  logic                             div_bit;
  logic [tcvd_pkg::QuoBits-1:0]     quo_nx;
  logic [tcvd_pkg::QuoBits-1:0]     sq_try, sq_res_nx;
  logic                             sq_fit;
  logic signed [SW:0]               vcand;
  logic signed [SW+2:0]             wsum;
  logic signed [SW-1:0]             wsat;
  logic [1:0]                       kind;
  logic                             bias_hit;
  logic [tcvd_pkg::LinkAw-1:0]      wr_addr, rd_addr;
  logic [tcvd_pkg::SqW+3:0]         q12;
  logic [tcvd_pkg::N2W-1:0]         diff;

  localparam logic signed [SW+2:0] SatHi = (SW+3)'((64'sd1 <<< (SW-1)) - 64'sd1);
  localparam logic signed [SW+2:0] SatLo = (SW+3)'(-(64'sd1 <<< (SW-1)));

  assign xsq  = 32'(bin_value_i) * 32'(bin_value_i);
  assign tsum = 18'(bins_q[0]) + 18'(s_q[0] ? bins_q[3] : bins_q[4]) + 18'(bins_q[7]);
  assign nval = $signed({2'b00, tsum, 2'b00}) - $signed(22'(a_q));
  assign q12  = {q_q, 3'b000} + {1'b0, q_q, 2'b00};
  assign diff = tcvd_pkg::N2W'(q12) - asq_q;

  // restoring division step
  assign r2      = {rem_q[tcvd_pkg::DW-1:0], 1'b0};
  assign div_bit = (r2 >= {1'b0, d_q});
  assign quo_nx  = {quo_q[tcvd_pkg::QuoBits-2:0], div_bit};

  // restoring square root step
  assign sq_try    = sq_res_q + sq_one_q;
  assign sq_fit    = (sq_op_q >= sq_try);
  assign sq_res_nx = sq_fit ? ((sq_res_q >> 1) + sq_one_q) : (sq_res_q >> 1);

  // add-compare-select candidate, stay bonus only in the decode sweep
  assign vcand = $signed({ps_q[p_q][SW-1], ps_q[p_q]})
               + ((cmd_i.acs_step && (p_q == s_q))
                  ? $signed({{(SW+1-16){stay_q[15]}}, stay_q}) : $signed((SW+1)'(0)));

  assign kind     = tcvd_pkg::diatonic_kind(s_q[tcvd_pkg::StateW-1:1], tonic_q, major_q);
  assign bias_hit = (kind == tcvd_pkg::KindMajor && !s_q[0])
                 || (kind == tcvd_pkg::KindMinor &&  s_q[0]);

  assign wsum = (sts_o.beat_zero ? $signed((SW+3)'(0))
                                 : $signed({{2{best_q[SW]}}, best_q}))
              + $signed({{(SW+3-16){em_q[15]}}, em_q})
              + (bias_hit ? $signed({{(SW+3-16){dbias_q[15]}}, dbias_q})
                          : $signed((SW+3)'(0)));

  always_comb begin
    if (wsum > SatHi)      wsat = SatHi[SW-1:0];
    else if (wsum < SatLo) wsat = SatLo[SW-1:0];
    else                   wsat = wsum[SW-1:0];
  end

  assign wr_addr = tcvd_pkg::LinkAw'(beat_q[tcvd_pkg::BeatIdxW-1:0]) *
                   tcvd_pkg::LinkAw'(tcvd_pkg::NStates) + tcvd_pkg::LinkAw'(s_q);
  assign rd_addr = tcvd_pkg::LinkAw'(tb_b_q) *
                   tcvd_pkg::LinkAw'(tcvd_pkg::NStates) + tcvd_pkg::LinkAw'(tb_s_q);

  // status
  assign sts_o.bin_last  = (bin_cnt_q == 4'(tcvd_pkg::NBins - 1));
  assign sts_o.fin       = fin_q;
  assign sts_o.beat_full = (beat_q == tcvd_pkg::BeatW'(tcvd_pkg::MaxBeats));
  assign sts_o.beat_zero = (beat_q == '0);
  assign sts_o.d_zero    = (d_q == '0);
  assign sts_o.n2_ge_d   = ({2'b00, n2_q} >= d_q);
  assign sts_o.div_last  = (step_q == tcvd_pkg::StepW'(tcvd_pkg::QuoBits - 1));
  assign sts_o.sqrt_last = (step_q == tcvd_pkg::StepW'(tcvd_pkg::SqrtBits - 1));
  assign sts_o.p_last    = (p_q == tcvd_pkg::StateW'(tcvd_pkg::NStates - 1));
  assign sts_o.s_last    = (s_q == tcvd_pkg::StateW'(tcvd_pkg::NStates - 1));
  assign sts_o.tb_zero   = (tb_b_q == '0);

  assign chord_root_o  = 4'(tb_s_q[tcvd_pkg::StateW-1:1]);
  assign chord_minor_o = tb_s_q[0];
  assign beat_index_o  = tb_b_q;
  assign last_chord_o  = (tb_b_q == '0);

  // control counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_cnt_q <= '0;
      beat_q    <= '0;
      s_q       <= '0;
      p_q       <= '0;
      step_q    <= '0;
    end else begin
      if (cmd_i.bin_take) bin_cnt_q <= sts_o.bin_last ? '0 : bin_cnt_q + 4'd1;
      if (cmd_i.copy)     beat_q <= beat_q + tcvd_pkg::BeatW'(1);
      if (cmd_i.tb_done)  beat_q <= '0;
      if (cmd_i.wr)       s_q <= sts_o.s_last ? '0 : s_q + tcvd_pkg::StateW'(1);
      if (cmd_i.acs_step || cmd_i.pick_step)
        p_q <= sts_o.p_last ? '0 : p_q + tcvd_pkg::StateW'(1);
      if (cmd_i.em_chk) step_q <= '0;
      if (cmd_i.div_step)
        step_q <= sts_o.div_last ? '0 : step_q + tcvd_pkg::StepW'(1);
      if (cmd_i.sqrt_step) step_q <= step_q + tcvd_pkg::StepW'(1);
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.bin_take) begin
      for (int i = 0; i < tcvd_pkg::NBins - 1; i++) bins_q[i] <= bins_q[i+1];
      bins_q[tcvd_pkg::NBins-1] <= bin_value_i;
      fin_q <= final_beat_i;
      if (bin_cnt_q == '0) begin
        a_q <= tcvd_pkg::SumW'(bin_value_i);
        q_q <= tcvd_pkg::SqW'(xsq);
      end else begin
        a_q <= a_q + tcvd_pkg::SumW'(bin_value_i);
        q_q <= q_q + tcvd_pkg::SqW'(xsq);
      end
    end
    // next root: rotate the chroma so the root sits at tap 0
    if (cmd_i.wr && s_q[0]) begin
      for (int i = 0; i < tcvd_pkg::NBins - 1; i++) bins_q[i] <= bins_q[i+1];
      bins_q[tcvd_pkg::NBins-1] <= bins_q[0];
    end
    if (cmd_i.prep_sq) asq_q <= tcvd_pkg::N2W'(a_q) * tcvd_pkg::N2W'(a_q);
    if (cmd_i.prep_d)  d_q   <= {diff, 1'b0} + tcvd_pkg::DW'(diff);
    if (cmd_i.em_n) begin
      nneg_q <= nval[21];
      nmag_q <= tcvd_pkg::SumW'(nval[21] ? -nval : nval);
    end
    if (cmd_i.em_sq) n2_q <= tcvd_pkg::N2W'(nmag_q) * tcvd_pkg::N2W'(nmag_q);
    if (cmd_i.em_chk) begin
      rem_q <= (tcvd_pkg::DW+1)'(n2_q);
      quo_q <= '0;
      k_q   <= sts_o.d_zero ? 15'd0 : 15'd16384;
    end
    if (cmd_i.div_step) begin
      rem_q <= div_bit ? (r2 - {1'b0, d_q}) : r2;
      quo_q <= quo_nx;
      if (sts_o.div_last) begin
        sq_op_q  <= quo_nx;
        sq_res_q <= '0;
        sq_one_q <= tcvd_pkg::QuoBits'(1) << (tcvd_pkg::QuoBits - 2);
      end
    end
    if (cmd_i.sqrt_step) begin
      if (sq_fit) sq_op_q <= sq_op_q - sq_try;
      sq_res_q <= sq_res_nx;
      sq_one_q <= sq_one_q >> 2;
      if (sts_o.sqrt_last) k_q <= 15'(sq_res_nx);
    end
    if (cmd_i.em_fin) em_q <= nneg_q ? -$signed({1'b0, k_q}) : $signed({1'b0, k_q});
    if (cmd_i.acs_step || cmd_i.pick_step) begin
      if (p_q == '0 || vcand > best_q) begin
        best_q <= vcand;
        arg_q  <= p_q;
      end
    end
    if (cmd_i.wr) nx_q[s_q] <= wsat;
    if (cmd_i.copy) begin
      for (int i = 0; i < tcvd_pkg::NStates; i++) ps_q[i] <= nx_q[i];
    end
    if (cmd_i.tb_init) begin
      tb_s_q <= arg_q;
      tb_b_q <= tcvd_pkg::BeatIdxW'(beat_q - tcvd_pkg::BeatW'(1));
    end
    if (cmd_i.tb_load) begin
      tb_s_q <= rd_q;
      tb_b_q <= tb_b_q - tcvd_pkg::BeatIdxW'(1);
    end
  end

  // back-link memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr && !sts_o.beat_zero) link_mem[wr_addr] <= arg_q;
    if (cmd_i.tb_read) rd_q <= link_mem[rd_addr];
  end

endmodule

`default_nettype wire

[rtl/core/tcvd_checker.sv]
// ----------------------------------------------------------------------------
// tcvd_checker
// port-level checks on the chord decoder, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module tcvd_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_stall_o,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic [3:0] chord_root_o,
  input wire logic       chord_minor_o,
  input wire logic [5:0] beat_index_o,
  input wire logic       last_chord_o
);

  // no result while bins are being taken
  a_no_out_collect: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> !out_valid_o)
    else $error("result shown while collecting bins");

  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(chord_root_o)
      && $stable(chord_minor_o) && $stable(beat_index_o) && $stable(last_chord_o))
    else $error("stalled result changed");

  // traceback needs a memory read between results
  a_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i |=> !out_valid_o)
    else $error("results back to back");

  // final flag marks beat zero and a legal root
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_chord_o == (beat_index_o == 6'd0)) && (chord_root_o <= 4'd11))
    else $error("bad last flag or root");

endmodule

bind triad_chord_viterbi_decoder_unit tcvd_checker u_tcvd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .chord_root_o  (chord_root_o),
  .chord_minor_o (chord_minor_o),
  .beat_index_o  (beat_index_o),
  .last_chord_o  (last_chord_o)
);

`default_nettype wire

[test/triad_chord_viterbi_decoder_unit_test.sv]
// ----------------------------------------------------------------------------
// triad_chord_viterbi_decoder_unit_test
// checks decoded chord items against a beat-level viterbi predictor
// ----------------------------------------------------------------------------
// bins are queued beat by beat and fed by a driver with random idle bursts.
// every accepted bin goes through a predictor that scores the beat, runs the
// compare-select step and traces back on the final beat. the monitor stalls
// at random and compares each chord item with the oldest expected one.
// register settings change between phases, once the block has gone quiet.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module triad_chord_viterbi_decoder_unit_test;

  localparam int Scores = 24;
  localparam longint ScoreHi = (64'sd1 <<< (tcvd_pkg::ScoreW - 1)) - 1;
  localparam longint ScoreLo = -ScoreHi - 1;
  localparam int QuietCycles = 2500;

  typedef struct {
    logic [tcvd_pkg::BinW-1:0] value;
    logic                      fin_mark;
  } bin_item_t;

  typedef struct {
    logic [3:0]                    root;
    logic                          minor;
    logic [tcvd_pkg::BeatIdxW-1:0] beat;
    logic                          last;
  } chord_item_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [tcvd_pkg::BinW-1:0] bin_value_i = '0;
  logic final_beat_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [3:0] chord_root_o;
  logic chord_minor_o;
  logic [tcvd_pkg::BeatIdxW-1:0] beat_index_o;
  logic last_chord_o;
  logic cfg_we_i = 1'b0;
  logic [tcvd_pkg::CfgIdxW-1:0] cfg_idx_i = tcvd_pkg::CfgKeyTonic;
  logic [tcvd_pkg::CfgDataW-1:0] cfg_data_i = '0;

  triad_chord_viterbi_decoder_unit dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // pending bin items and expected chord items
  bin_item_t   bin_q[$];
  chord_item_t chord_q[$];
  int          mismatches = 0;
  bit          calm = 1'b0;   // no idling on either side

  // predictor state and register mirror
  logic [3:0]  key_tonic_m = 4'd0;
  logic        key_major_m = 1'b1;
  longint      stay_m = 0;
  longint      bias_m = 0;
  logic [tcvd_pkg::BinW-1:0] beat_bins [tcvd_pkg::NBins];
  int          bins_seen = 0;
  longint      path_score [Scores];
  logic [4:0]  back_link [tcvd_pkg::MaxBeats * Scores];
  int          beats_held = 0;

  // correlation of one template, q.14, sign of n times the exact floor of 16384*|n|/sqrt(d)
  function automatic longint correlation(longint n, longint unsigned d);
    logic [127:0] target, prod;
    longint unsigned mag, lo, hi, mid;
    mag = (n < 0) ? -n : n;
    target = 128'(mag * mag) << 28;
    lo = 0;
    hi = 16384;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      prod = 128'(mid * mid) * 128'(d);
      if (prod <= target) lo = mid;
      else hi = mid - 1;
    end
    return (n < 0) ? -longint'(lo) : longint'(lo);
  endfunction

  // 0 major, 1 minor, 2 diminished for a root in the mirrored key
  function automatic int key_quality(int root);
    int deg;
    deg = (root + 24 - int'(key_tonic_m)) % 12;
    if (key_major_m) begin
      if (deg == 2 || deg == 4 || deg == 9) return 1;
      if (deg == 11) return 2;
      return 0;
    end
    if (deg == 2) return 2;
    if (deg == 3 || deg == 7 || deg == 8 || deg == 10) return 0;
    return 1;
  endfunction

  function automatic longint clip_score(longint v);
    if (v > ScoreHi) return ScoreHi;
    if (v < ScoreLo) return ScoreLo;
    return v;
  endfunction

  // viterbi step for the beat now held in beat_bins
  task automatic score_beat(int b);
    longint em [Scores];
    longint nxt [Scores];
    longint unsigned a, q, d, t;
    longint best, v, bias;
    int arg, third;
    a = 0;
    q = 0;
    for (int i = 0; i < tcvd_pkg::NBins; i++) begin
      a += beat_bins[i];
      q += longint'(beat_bins[i]) * longint'(beat_bins[i]);
    end
    d = 3 * (12 * q - a * a);
    for (int s = 0; s < Scores; s++) begin
      third = (s % 2) ? 3 : 4;
      t = beat_bins[s/2] + beat_bins[(s/2 + third) % 12] + beat_bins[(s/2 + 7) % 12];
      em[s] = (d == 0) ? 0 : correlation(4 * longint'(t) - longint'(a), d);
    end
    for (int s = 0; s < Scores; s++) begin
      bias = (key_quality(s / 2) == s % 2) ? bias_m : 0;
      if (b == 0) begin
        nxt[s] = clip_score(em[s] + bias);
      end else begin
        best = path_score[0] + ((s == 0) ? stay_m : 0);
        arg = 0;
        for (int p = 1; p < Scores; p++) begin
          v = path_score[p] + ((p == s) ? stay_m : 0);
          if (v > best) begin
            best = v;
            arg = p;
          end
        end
        nxt[s] = clip_score(best + em[s] + bias);
        back_link[b * Scores + s] = 5'(arg);
      end
    end
    path_score = nxt;
  endtask

  // takes one accepted bin, queues chord items on a final beat
  task automatic absorb_bin(bin_item_t it);
    int s, b;
    chord_item_t c;
    beat_bins[bins_seen] = it.value;
    bins_seen++;
    if (bins_seen < tcvd_pkg::NBins) return;
    bins_seen = 0;
    if (beats_held < tcvd_pkg::MaxBeats) begin
      score_beat(beats_held);
      beats_held++;
    end
    if (!it.fin_mark) return;
    s = 0;
    for (int p = 1; p < Scores; p++)
      if (path_score[p] > path_score[s]) s = p;
    for (b = beats_held - 1; b >= 0; b--) begin
      c.root = 4'(s / 2);
      c.minor = 1'(s % 2);
      c.beat = tcvd_pkg::BeatIdxW'(b);
      c.last = (b == 0);
      chord_q.insert(chord_q.size(), c);
      if (b > 0) s = back_link[b * Scores + s];
    end
    beats_held = 0;
  endtask

  // driver: one bin item at a time, random idle bursts
  int  send_gap = 0;
  bit  in_fire;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      in_fire = in_valid_i && !in_stall_o;
      if (in_fire) begin
        absorb_bin(bin_q[0]);
        void'(bin_q.pop_front());
      end
      if (in_valid_i && !in_fire) begin
        // stalled item holds
      end else if (send_gap > 0) begin
        send_gap--;
        in_valid_i <= 1'b0;
      end else if (bin_q.size() > 0 && !calm && $urandom_range(0, 5) == 0) begin
        send_gap = $urandom_range(0, 4);
        in_valid_i <= 1'b0;
      end else if (bin_q.size() > 0) begin
        in_valid_i <= 1'b1;
        bin_value_i <= bin_q[0].value;
        final_beat_i <= bin_q[0].fin_mark;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // monitor: random stall bursts, field by field compare
  int stall_left = 0;
  chord_item_t want;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (chord_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected chord item: root %0d minor %0d beat %0d last %0d",
                     chord_root_o, chord_minor_o, beat_index_o, last_chord_o);
        end else begin
          want = chord_q.pop_front();
          if (chord_root_o !== want.root || chord_minor_o !== want.minor ||
              beat_index_o !== want.beat || last_chord_o !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("chord mismatch: want %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                       want.root, want.minor, want.beat, want.last,
                       chord_root_o, chord_minor_o, beat_index_o, last_chord_o);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 4);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // queue one beat of twelve bins; only the twelfth carries the real mark
  task automatic queue_beat(int style, bit fin_mark);
    bin_item_t it;
    logic [tcvd_pkg::BinW-1:0] level;
    int root, third;
    level = tcvd_pkg::BinW'($urandom);
    root = $urandom_range(0, 11);
    third = $urandom_range(0, 1) ? 3 : 4;
    for (int i = 0; i < tcvd_pkg::NBins; i++) begin
      case (style)
        0: it.value = tcvd_pkg::BinW'($urandom);
        1: begin
          it.value = tcvd_pkg::BinW'($urandom_range(0, 9000));
          if (i == root || i == (root + third) % 12 || i == (root + 7) % 12)
            it.value = tcvd_pkg::BinW'($urandom_range(30000, 65535));
        end
        2: it.value = level;
        3: it.value = '0;
        default: it.value = tcvd_pkg::BinW'($urandom_range(0, 3));
      endcase
      it.fin_mark = (i == tcvd_pkg::NBins - 1) ? fin_mark : 1'($urandom);
      bin_q.insert(bin_q.size(), it);
    end
  endtask

  task automatic queue_sequence(int beats);
    int style;
    for (int b = 0; b < beats; b++) begin
      style = $urandom_range(0, 9);
      style = (style < 5) ? 1 : style - 5;
      queue_beat(style, b == beats - 1);
    end
  endtask

  // block quiet: all bins taken, all chords seen, beat work drained
  task automatic wait_quiet();
    while (bin_q.size() > 0 || chord_q.size() > 0) @(posedge clk_i);
    repeat (QuietCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [tcvd_pkg::CfgIdxW-1:0] idx,
                           logic [tcvd_pkg::CfgDataW-1:0] value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    case (idx)
      tcvd_pkg::CfgKeyTonic:     key_tonic_m = value[3:0];
      tcvd_pkg::CfgKeyMajor:     key_major_m = value[0];
      tcvd_pkg::CfgStayBonus:    stay_m = longint'($signed(value));
      tcvd_pkg::CfgDiatonicBias: bias_m = longint'($signed(value));
      default:                   ;
    endcase
  endtask

  task automatic set_key(logic [3:0] tonic, logic major, logic [15:0] stay,
                         logic [15:0] bias);
    write_reg(tcvd_pkg::CfgKeyTonic, tcvd_pkg::CfgDataW'(tonic));
    write_reg(tcvd_pkg::CfgKeyMajor, tcvd_pkg::CfgDataW'(major));
    write_reg(tcvd_pkg::CfgStayBonus, stay);
    write_reg(tcvd_pkg::CfgDiatonicBias, bias);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    bin_item_t it;
    int queued;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: extreme alternating bins, then a flat full-scale final beat
    for (int i = 0; i < tcvd_pkg::NBins; i++) begin
      it.value = (i % 2) ? '0 : '1;
      it.fin_mark = (i == tcvd_pkg::NBins - 1) ? 1'b0 : 1'b1;
      bin_q.insert(bin_q.size(), it);
    end
    for (int i = 0; i < tcvd_pkg::NBins; i++) begin
      it.value = '1;
      it.fin_mark = (i == tcvd_pkg::NBins - 1);
      bin_q.insert(bin_q.size(), it);
    end
    wait_quiet();

    for (int ph = 1; ph <= 9; ph++) begin
      case (ph)
        1: set_key(4'd15, 1'b0, 16'h7fff, 16'h8000);
        2: set_key(4'd0, 1'b1, 16'h8000, 16'h7fff);
        3: set_key(4'd11, 1'b1, 16'h7fff, 16'h7fff);
        default: set_key(4'($urandom), 1'($urandom), 16'($urandom), 16'($urandom));
      endcase
      calm = (ph == 9) || ($urandom_range(0, 3) == 0);
      if (ph == 4) queue_sequence(1);
      queued = 0;
      while (queued < 4) begin
        int n;
        n = $urandom_range(1, 3);
        queue_sequence(n);
        queued += n;
      end
      wait_quiet();
    end

    if (chord_q.size() != 0) mismatches++;
    if (mismatches == 0) $display("triad_chord_viterbi_decoder_unit_test OK");
    else $display("triad_chord_viterbi_decoder_unit_test NOT OK");
    $finish;
  end

  initial begin
    #20ms;
    $display("triad_chord_viterbi_decoder_unit_test NOT OK");
    $finish;
  end

endmodule

[triad_chord_viterbi_decoder_unit.f]
rtl/core/tcvd_pkg.sv
rtl/core/tcvd_ctrl.sv
rtl/core/tcvd_dpath.sv
rtl/core/triad_chord_viterbi_decoder_unit.sv
rtl/core/tcvd_checker.sv
test/triad_chord_viterbi_decoder_unit_test.sv
